### sv/sgorr_pkg.sv
// types and constants for the spread gated order risk router
// no dependencies; used by spread_gated_order_risk_router_unit
package sgorr_pkg;

	localparam int CNT_W = 32;

	localparam int PRICE_W = 32;
	localparam int QTY_W   = 31;
	localparam int POS_W   = 32;
	localparam int SEQ_W   = 64;
	localparam int LOC_W   = 16;
	localparam int TIME_W  = 64;
	localparam int OUT_CNT_W = 32;
	localparam int WIDE_W  = POS_W + 2;

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	typedef enum logic [1:0] {
		KIND_BOOK  = 2'd0,
		KIND_FILL  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_NONE      = 2'd0,
		STAT_SUBMITTED = 2'd1,
		STAT_REJECTED  = 2'd2,
		STAT_UNUSED    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_LONG_LIMIT    = 2'd0,
		REG_SHORT_LIMIT   = 2'd1,
		REG_SPREAD_LIMIT  = 2'd2,
		REG_BASE_QUANTITY = 2'd3
	} reg_idx_t;

	typedef enum logic {
		SIDE_BUY  = 1'b0,
		SIDE_SELL = 1'b1
	} side_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [PRICE_W-1:0]  best_bid;
		logic [PRICE_W-1:0]  best_ask;
		logic [LOC_W-1:0]    instrument_locate;
		logic [TIME_W-1:0]   time_ns;
		logic [QTY_W-1:0]    filled_quantity;
		logic                fill_was_buy;
	} item_t;

	typedef struct packed {
		status_t             status;
		logic [SEQ_W-1:0]    number;
		side_t               side;
		logic [PRICE_W-1:0]  price;
		logic [QTY_W-1:0]    quantity;
		logic [LOC_W-1:0]    locate;
		logic [TIME_W-1:0]   time_ns;
		logic [POS_W-1:0]    position;
		logic [OUT_CNT_W-1:0] submitted;
		logic [OUT_CNT_W-1:0] rejected;
		logic [OUT_CNT_W-1:0] fills;
	} result_t;

endpackage

### sv/spread_gated_order_risk_router_unit.sv
// spread gated order router with position risk gate, top level
// depends on sgorr_pkg
//
// usage: market events enter on the in channel (in_valid / in_stall), one item
// being a top-of-book update, a fill or a clear of the statistics counters.
// every item gives exactly one result on the out channel (out_valid /
// out_stall): order status, the proposed order fields and the position and
// counters after the item.
// registers long_limit, short_limit, spread_limit and base_quantity are written
// through the cfg channel (cfg_valid / cfg_ready, index 0 to 3); cfg_ready is
// always high; writes must be made by the user while the block is idle, as
// the block does not enforce it. An accepted item is held in the input register
// and its result in the result register, which drives the out ports.
// throughput: one item per cycle while out_stall is low; the position, sequence
// and counters update as the item moves from the input to the result register.
// when the receiver stalls, the result register holds and the input register
// still takes one more item; in_stall rises only when both are full and
// out_stall is high.
// reset clears position, order sequence, counters, registers and both valids.
module spread_gated_order_risk_router_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [sgorr_pkg::PRICE_W-1:0]     best_bid,
	input  logic [sgorr_pkg::PRICE_W-1:0]     best_ask,
	input  logic [sgorr_pkg::LOC_W-1:0]       instrument_locate,
	input  logic [sgorr_pkg::TIME_W-1:0]      time_ns,
	input  logic [sgorr_pkg::QTY_W-1:0]       filled_quantity,
	input  logic                              fill_was_buy,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        event_status,
	output logic [sgorr_pkg::SEQ_W-1:0]       order_number,
	output logic                              order_side,
	output logic [sgorr_pkg::PRICE_W-1:0]     order_price,
	output logic [sgorr_pkg::QTY_W-1:0]       order_quantity,
	output logic [sgorr_pkg::LOC_W-1:0]       order_locate,
	output logic [sgorr_pkg::TIME_W-1:0]      order_time_ns,
	output logic signed [sgorr_pkg::POS_W-1:0] current_position,
	output logic [sgorr_pkg::OUT_CNT_W-1:0]   submitted_count,
	output logic [sgorr_pkg::OUT_CNT_W-1:0]   rejected_count,
	output logic [sgorr_pkg::OUT_CNT_W-1:0]   fill_count
);

	localparam int W = sgorr_pkg::WIDE_W;

	// configuration
	logic signed [sgorr_pkg::POS_W-1:0]   long_limit_q;
	logic signed [sgorr_pkg::POS_W-1:0]   short_limit_q;
	logic [sgorr_pkg::PRICE_W-1:0]        spread_limit_q;
	logic [sgorr_pkg::QTY_W-1:0]          base_qty_q;

	// block state
	logic signed [sgorr_pkg::POS_W-1:0]   pos_q;
	logic [sgorr_pkg::SEQ_W-1:0]          seq_q;
	logic [sgorr_pkg::CNT_W-1:0]          sub_cnt_q;
	logic [sgorr_pkg::CNT_W-1:0]          rej_cnt_q;
	logic [sgorr_pkg::CNT_W-1:0]          fill_cnt_q;

	// pipeline
	logic                   valid_s1;
	sgorr_pkg::item_t       item_s1;
	logic                   valid_s2;
	sgorr_pkg::result_t     res_s2;

	logic                   in_accept;
	logic                   adv_s1;
	logic                   out_take;

	// datapath
	logic                                 book_ok;
	logic [sgorr_pkg::PRICE_W-1:0]        spread;
	logic                                 flat;
	logic                                 is_long;
	logic                                 propose;
	logic [sgorr_pkg::QTY_W-1:0]          unwind_qty;
	logic [sgorr_pkg::QTY_W-1:0]          qty;
	logic signed [W-1:0]                  pos_w;
	logic signed [W-1:0]                  qty_w;
	logic signed [W-1:0]                  proj_w;
	logic signed [W-1:0]                  fqty_w;
	logic signed [W-1:0]                  fill_w;
	logic signed [sgorr_pkg::POS_W-1:0]   fill_pos;
	logic                                 reject;
	logic [sgorr_pkg::SEQ_W-1:0]          seq_inc;

	logic signed [sgorr_pkg::POS_W-1:0]   pos_d;
	logic [sgorr_pkg::SEQ_W-1:0]          seq_d;
	logic [sgorr_pkg::CNT_W-1:0]          sub_d;
	logic [sgorr_pkg::CNT_W-1:0]          rej_d;
	logic [sgorr_pkg::CNT_W-1:0]          fill_d;
	sgorr_pkg::result_t                   res_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_limit_q   <= '0;
			short_limit_q  <= '0;
			spread_limit_q <= '0;
			base_qty_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sgorr_pkg::REG_LONG_LIMIT:    long_limit_q   <= $signed(cfg_data);
				sgorr_pkg::REG_SHORT_LIMIT:   short_limit_q  <= $signed(cfg_data);
				sgorr_pkg::REG_SPREAD_LIMIT:  spread_limit_q <= cfg_data;
				sgorr_pkg::REG_BASE_QUANTITY: base_qty_q     <= cfg_data[sgorr_pkg::QTY_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign out_take  = valid_s2 && !out_stall;
	assign adv_s1    = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_accept)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (out_take)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.kind              <= kind;
			item_s1.best_bid          <= best_bid;
			item_s1.best_ask          <= best_ask;
			item_s1.instrument_locate <= instrument_locate;
			item_s1.time_ns           <= time_ns;
			item_s1.filled_quantity   <= filled_quantity;
			item_s1.fill_was_buy      <= fill_was_buy;
		end
		if (adv_s1)
			res_s2 <= res_d;
	end

	// order proposal and risk gate
	assign spread  = item_s1.best_ask - item_s1.best_bid;
	assign book_ok = (item_s1.best_bid != '0) && (item_s1.best_ask != '0) &&
		(item_s1.best_ask >= item_s1.best_bid) && (spread <= spread_limit_q);
	assign flat    = (pos_q == '0);
	assign is_long = !pos_q[sgorr_pkg::POS_W-1] && !flat;
	assign propose = (item_s1.kind == sgorr_pkg::KIND_BOOK) && book_ok && (flat || is_long);

	// position is positive here, so its low bits hold it exactly
	assign unwind_qty = ({1'b0, base_qty_q} < pos_q) ? base_qty_q
		: pos_q[sgorr_pkg::QTY_W-1:0];
	assign qty = is_long ? unwind_qty : base_qty_q;

	assign pos_w  = W'(pos_q);
	assign qty_w  = $signed(W'(qty));
	assign proj_w = is_long ? pos_w - qty_w : pos_w + qty_w;
	assign reject = (qty == '0) || (proj_w > W'(long_limit_q)) ||
		(proj_w < W'(short_limit_q));
	assign seq_inc = seq_q + sgorr_pkg::SEQ_W'(1);

	// fill with saturation
	assign fqty_w = $signed(W'(item_s1.filled_quantity));
	assign fill_w = item_s1.fill_was_buy ? pos_w + fqty_w : pos_w - fqty_w;

	always_comb begin
		if (fill_w > W'(sgorr_pkg::POS_MAX))
			fill_pos = sgorr_pkg::POS_MAX;
		else if (fill_w < W'(sgorr_pkg::POS_MIN))
			fill_pos = sgorr_pkg::POS_MIN;
		else
			fill_pos = fill_w[sgorr_pkg::POS_W-1:0];
	end

	always_comb begin
		pos_d  = pos_q;
		seq_d  = seq_q;
		sub_d  = sub_cnt_q;
		rej_d  = rej_cnt_q;
		fill_d = fill_cnt_q;
		res_d  = '0;
		case (item_s1.kind)
			sgorr_pkg::KIND_BOOK: begin
				if (propose) begin
					seq_d            = seq_inc;
					res_d.number     = seq_inc;
					res_d.side       = is_long ? sgorr_pkg::SIDE_SELL : sgorr_pkg::SIDE_BUY;
					res_d.price      = is_long ? item_s1.best_bid : item_s1.best_ask;
					res_d.quantity   = qty;
					res_d.locate     = item_s1.instrument_locate;
					res_d.time_ns    = item_s1.time_ns;
					if (reject) begin
						rej_d        = rej_cnt_q + sgorr_pkg::CNT_W'(1);
						res_d.status = sgorr_pkg::STAT_REJECTED;
					end else begin
						sub_d        = sub_cnt_q + sgorr_pkg::CNT_W'(1);
						res_d.status = sgorr_pkg::STAT_SUBMITTED;
					end
				end
			end
			sgorr_pkg::KIND_FILL: begin
				fill_d = fill_cnt_q + sgorr_pkg::CNT_W'(1);
				pos_d  = fill_pos;
			end
			sgorr_pkg::KIND_CLEAR: begin
				sub_d  = '0;
				rej_d  = '0;
				fill_d = '0;
			end
			default: ;
		endcase
		res_d.position  = pos_d;
		res_d.submitted = sgorr_pkg::OUT_CNT_W'(sub_d);
		res_d.rejected  = sgorr_pkg::OUT_CNT_W'(rej_d);
		res_d.fills     = sgorr_pkg::OUT_CNT_W'(fill_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			seq_q      <= '0;
			sub_cnt_q  <= '0;
			rej_cnt_q  <= '0;
			fill_cnt_q <= '0;
		end else if (adv_s1) begin
			pos_q      <= pos_d;
			seq_q      <= seq_d;
			sub_cnt_q  <= sub_d;
			rej_cnt_q  <= rej_d;
			fill_cnt_q <= fill_d;
		end
	end

	assign out_valid        = valid_s2;
	assign event_status     = res_s2.status;
	assign order_number     = res_s2.number;
	assign order_side       = res_s2.side;
	assign order_price      = res_s2.price;
	assign order_quantity   = res_s2.quantity;
	assign order_locate     = res_s2.locate;
	assign order_time_ns    = res_s2.time_ns;
	assign current_position = res_s2.position;
	assign submitted_count  = res_s2.submitted;
	assign rejected_count   = res_s2.rejected;
	assign fill_count       = res_s2.fills;

`ifndef SYNTH
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res_d.status != sgorr_pkg::STAT_NONE) |=>
		seq_q == $past(seq_q) + sgorr_pkg::SEQ_W'(1))
		else $error("order sequence did not step on an order");

	a_seq_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_d.status == sgorr_pkg::STAT_NONE || !adv_s1) |=> $stable(seq_q))
		else $error("order sequence moved without an order");

	a_submit_qty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res_s2.status == sgorr_pkg::STAT_SUBMITTED) |->
		res_s2.quantity != '0)
		else $error("submitted order with zero quantity");

	a_no_order_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res_s2.status == sgorr_pkg::STAT_NONE) |->
		(res_s2.number == '0 && res_s2.quantity == '0 && res_s2.price == '0))
		else $error("order fields set without an order");
`endif

endmodule

### tb/sv/spread_gated_order_risk_router_unit_tb.sv
// testbench for spread_gated_order_risk_router_unit: directed and random market events
// checked against an in-bench position, sequence and counter tracker; depends on sgorr_pkg
`timescale 1ns / 100ps

module spread_gated_order_risk_router_unit_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 40;
	localparam longint POS_HI = 64'sd2147483647;
	localparam longint POS_LO = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] kind = '0;
	logic [sgorr_pkg::PRICE_W-1:0] best_bid = '0;
	logic [sgorr_pkg::PRICE_W-1:0] best_ask = '0;
	logic [sgorr_pkg::LOC_W-1:0] instrument_locate = '0;
	logic [sgorr_pkg::TIME_W-1:0] time_ns = '0;
	logic [sgorr_pkg::QTY_W-1:0] filled_quantity = '0;
	logic fill_was_buy = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] event_status;
	logic [sgorr_pkg::SEQ_W-1:0] order_number;
	logic order_side;
	logic [sgorr_pkg::PRICE_W-1:0] order_price;
	logic [sgorr_pkg::QTY_W-1:0] order_quantity;
	logic [sgorr_pkg::LOC_W-1:0] order_locate;
	logic [sgorr_pkg::TIME_W-1:0] order_time_ns;
	logic signed [sgorr_pkg::POS_W-1:0] current_position;
	logic [sgorr_pkg::OUT_CNT_W-1:0] submitted_count;
	logic [sgorr_pkg::OUT_CNT_W-1:0] rejected_count;
	logic [sgorr_pkg::OUT_CNT_W-1:0] fill_count;

	spread_gated_order_risk_router_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .best_bid(best_bid),
		.best_ask(best_ask), .instrument_locate(instrument_locate), .time_ns(time_ns),
		.filled_quantity(filled_quantity), .fill_was_buy(fill_was_buy),
		.out_valid(out_valid), .out_stall(out_stall), .event_status(event_status),
		.order_number(order_number), .order_side(order_side), .order_price(order_price),
		.order_quantity(order_quantity), .order_locate(order_locate),
		.order_time_ns(order_time_ns), .current_position(current_position),
		.submitted_count(submitted_count), .rejected_count(rejected_count),
		.fill_count(fill_count)
	);

	always #10 clk = ~clk;

	// limits as last written
	logic signed [31:0] long_lim = '0;
	logic signed [31:0] short_lim = '0;
	logic [31:0] spread_lim = '0;
	logic [30:0] base_qty = '0;

	// tracked book-keeping state
	logic signed [sgorr_pkg::POS_W-1:0] position = '0;
	logic [sgorr_pkg::SEQ_W-1:0] sequence_id = '0;
	logic [sgorr_pkg::CNT_W-1:0] submitted_total = '0;
	logic [sgorr_pkg::CNT_W-1:0] rejected_total = '0;
	logic [sgorr_pkg::CNT_W-1:0] fill_total = '0;

	sgorr_pkg::item_t market_events[$];
	sgorr_pkg::result_t expected_reports[$];
	sgorr_pkg::item_t offered;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int unsigned cfg_writes = 0;
	int unsigned events_routed = 0;
	int unsigned reports_checked = 0;
	int unsigned seen_submitted = 0;
	int unsigned seen_rejected = 0;
	int unsigned seen_no_order = 0;
	int errors = 0;
	int quiet_cycles = 0;

	function automatic sgorr_pkg::result_t route_event(sgorr_pkg::item_t ev);
		sgorr_pkg::result_t r;
		longint proj;
		logic [30:0] qty;
		r = '0;
		case (sgorr_pkg::kind_t'(ev.kind))
			sgorr_pkg::KIND_BOOK: begin
				if (ev.best_bid != 0 && ev.best_ask != 0 && ev.best_ask >= ev.best_bid &&
				    (ev.best_ask - ev.best_bid) <= spread_lim && position >= 0) begin
					if (position == 0) begin
						r.side = sgorr_pkg::SIDE_BUY;
						r.price = ev.best_ask;
						qty = base_qty;
					end else begin
						r.side = sgorr_pkg::SIDE_SELL;
						r.price = ev.best_bid;
						qty = ({1'b0, base_qty} < unsigned'(position)) ? base_qty
							: position[30:0];
					end
					sequence_id = sequence_id + 1'b1;
					r.number = sequence_id;
					r.quantity = qty;
					r.locate = ev.instrument_locate;
					r.time_ns = ev.time_ns;
					proj = (r.side == sgorr_pkg::SIDE_BUY)
						? longint'(position) + longint'(qty)
						: longint'(position) - longint'(qty);
					if (qty == 0 || proj > longint'(long_lim) ||
					    proj < longint'(short_lim)) begin
						rejected_total = rejected_total + 1'b1;
						r.status = sgorr_pkg::STAT_REJECTED;
					end else begin
						submitted_total = submitted_total + 1'b1;
						r.status = sgorr_pkg::STAT_SUBMITTED;
					end
				end
			end
			sgorr_pkg::KIND_FILL: begin
				fill_total = fill_total + 1'b1;
				proj = ev.fill_was_buy ? longint'(position) + longint'(ev.filled_quantity)
					: longint'(position) - longint'(ev.filled_quantity);
				if (proj > POS_HI)
					proj = POS_HI;
				if (proj < POS_LO)
					proj = POS_LO;
				position = proj[31:0];
			end
			sgorr_pkg::KIND_CLEAR: begin
				submitted_total = '0;
				rejected_total = '0;
				fill_total = '0;
			end
			default: ;
		endcase
		r.position = position;
		r.submitted = submitted_total[sgorr_pkg::OUT_CNT_W-1:0];
		r.rejected = rejected_total[sgorr_pkg::OUT_CNT_W-1:0];
		r.fills = fill_total[sgorr_pkg::OUT_CNT_W-1:0];
		return r;
	endfunction

	function automatic sgorr_pkg::item_t make_event(logic [1:0] k, logic [31:0] bid,
		logic [31:0] ask, logic [30:0] qty, logic buy);
		sgorr_pkg::item_t ev;
		ev.kind = k;
		ev.best_bid = bid;
		ev.best_ask = ask;
		ev.instrument_locate = 16'($urandom);
		ev.time_ns = {$urandom, $urandom};
		ev.filled_quantity = qty;
		ev.fill_was_buy = buy;
		return ev;
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_report();
		sgorr_pkg::result_t want;
		if (expected_reports.size() == 0) begin
			$display("%0t report with no item pending, status %0d", $time, event_status);
			errors++;
			return;
		end
		want = expected_reports.pop_front();
		reports_checked++;
		case (want.status)
			sgorr_pkg::STAT_SUBMITTED: seen_submitted++;
			sgorr_pkg::STAT_REJECTED: seen_rejected++;
			default: seen_no_order++;
		endcase
		compare_field("event_status", 64'(want.status), 64'(event_status));
		compare_field("order_number", want.number, order_number);
		compare_field("order_side", 64'(want.side), 64'(order_side));
		compare_field("order_price", 64'(want.price), 64'(order_price));
		compare_field("order_quantity", 64'(want.quantity), 64'(order_quantity));
		compare_field("order_locate", 64'(want.locate), 64'(order_locate));
		compare_field("order_time_ns", want.time_ns, order_time_ns);
		compare_field("current_position", 64'(want.position),
			64'(unsigned'(current_position)));
		compare_field("submitted_count", 64'(want.submitted), 64'(submitted_count));
		compare_field("rejected_count", 64'(want.rejected), 64'(rejected_count));
		compare_field("fill_count", 64'(want.fills), 64'(fill_count));
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_reports.push_back(route_event(offered));
				events_routed++;
			end
			if (!in_valid || !in_stall) begin
				if (market_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = market_events.pop_front();
					kind <= offered.kind;
					best_bid <= offered.best_bid;
					best_ask <= offered.best_ask;
					instrument_locate <= offered.instrument_locate;
					time_ns <= offered.time_ns;
					filled_quantity <= offered.filled_quantity;
					fill_was_buy <= offered.fill_was_buy;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_report();
			if (hold_req && !hold_taken) begin
				hold_left = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (sgorr_pkg::reg_idx_t'(cfg_index))
				sgorr_pkg::REG_LONG_LIMIT: long_lim = cfg_data;
				sgorr_pkg::REG_SHORT_LIMIT: short_lim = cfg_data;
				sgorr_pkg::REG_SPREAD_LIMIT: spread_lim = cfg_data;
				sgorr_pkg::REG_BASE_QUANTITY: base_qty = cfg_data[30:0];
				default: ;
			endcase
			cfg_writes++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic write_reg(sgorr_pkg::reg_idx_t idx, logic [31:0] val);
		int unsigned seen;
		seen = cfg_writes;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		wait (cfg_writes != seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(logic [31:0] lim_long, logic [31:0] lim_short,
		logic [31:0] spread, logic [31:0] qty);
		write_reg(sgorr_pkg::REG_LONG_LIMIT, lim_long);
		write_reg(sgorr_pkg::REG_SHORT_LIMIT, lim_short);
		write_reg(sgorr_pkg::REG_SPREAD_LIMIT, spread);
		write_reg(sgorr_pkg::REG_BASE_QUANTITY, qty);
	endtask

	task automatic drain();
		while (market_events.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_random_event();
		int unsigned pick;
		int unsigned bid;
		int unsigned gap;
		logic [30:0] big;
		pick = $urandom_range(99);
		bid = $urandom_range(1, 1000);
		gap = $urandom_range(0, 12);
		big = 31'($urandom);
		if (pick < 50) begin
			market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, bid, bid + gap, big,
				pick[0]));
		end else if (pick < 56) begin
			case (pick % 3)
				0: market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, 0, bid, big,
					1'b0));
				1: market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, bid, 0, big,
					1'b1));
				default: market_events.push_back(make_event(sgorr_pkg::KIND_BOOK,
					bid + gap + 1, bid, big, 1'b0));
			endcase
		end else if (pick < 80) begin
			market_events.push_back(make_event(sgorr_pkg::KIND_FILL, bid, bid + gap,
				31'($urandom_range(0, 24)), $urandom_range(2) != 0));
		end else if (pick < 84) begin
			// large fill and its unwind, so the position does not drift off for good
			market_events.push_back(make_event(sgorr_pkg::KIND_FILL, $urandom, $urandom,
				big, 1'b1));
			market_events.push_back(make_event(sgorr_pkg::KIND_FILL, $urandom, $urandom,
				big, 1'b0));
		end else if (pick < 88) begin
			market_events.push_back(make_event(sgorr_pkg::KIND_CLEAR, $urandom, $urandom,
				big, pick[0]));
		end else if (pick < 90) begin
			market_events.push_back(make_event(sgorr_pkg::KIND_NONE, bid, bid + gap, big,
				pick[0]));
		end else begin
			market_events.push_back(make_event(2'($urandom), $urandom, $urandom, big,
				1'($urandom)));
		end
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, logic [31:0] lim_long,
		logic [31:0] lim_short, logic [31:0] spread, logic [31:0] qty, int count);
		set_limits(lim_long, lim_short, spread, qty);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			queue_random_event();
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		set_limits(1000, -1000, 5, 10);
		market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, 0, 100, 0, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, 100, 0, 0, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, 105, 100, 0, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, 100, 106, 0, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, 100, 105, 0, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_FILL, 0, 0, 10, 1));
		market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, 100, 100, 0, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_FILL, 0, 0, 3, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, 200, 203, 0, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_FILL, 0, 0, 20, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, 100, 101, 0, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_FILL, 0, 0, 13, 1));
		market_events.push_back(make_event(sgorr_pkg::KIND_FILL, 0, 0, 31'h7fffffff, 1));
		market_events.push_back(make_event(sgorr_pkg::KIND_FILL, 0, 0, 5, 1));
		market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, 32'hffffffff,
			32'hffffffff, 0, 0));
		repeat (3)
			market_events.push_back(make_event(sgorr_pkg::KIND_FILL, 0, 0,
				31'h7fffffff, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_NONE, 32'hffffffff,
			32'hffffffff, 31'h7fffffff, 1));
		market_events.push_back(make_event(sgorr_pkg::KIND_CLEAR, 0, 0, 0, 0));
		market_events.push_back(make_event(sgorr_pkg::KIND_FILL, 0, 0, 31'h7fffffff, 1));
		market_events.push_back(make_event(sgorr_pkg::KIND_FILL, 0, 0, 1, 1));
		market_events.push_back(make_event(sgorr_pkg::KIND_BOOK, 1, 6, 0, 0));
		drain();

		hold_req = 1'b1;
		run_phase(0, 0, $urandom_range(10, 60), -$urandom_range(0, 60),
			$urandom_range(0, 10), $urandom_range(1, 20), 120);
		run_phase(87, 0, $urandom_range(10, 60), -$urandom_range(0, 60),
			$urandom_range(0, 10), $urandom_range(1, 20), 120);
		run_phase(0, 87, $urandom_range(10, 60), -$urandom_range(0, 60),
			$urandom_range(0, 10), $urandom_range(1, 20), 120);
		run_phase(34, 34, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'hffffffff, 100);
		run_phase(34, 34, 32'h80000000, 32'h7fffffff, 0, 0, 60);
		run_phase(0, 0, 40, $urandom_range(0, 15), $urandom_range(3, 12),
			$urandom_range(1, 20), 130);

		repeat (8) @(posedge clk);
		$display("routed %0d events, checked %0d reports", events_routed, reports_checked);
		$display("(%0d submitted, %0d rejected, %0d no order), %0d register writes",
			seen_submitted, seen_rejected, seen_no_order, cfg_writes);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
sv/sgorr_pkg.sv
sv/spread_gated_order_risk_router_unit.sv
tb/sv/spread_gated_order_risk_router_unit_tb.sv
